/* hw/rtl/rgsr_pkg.sv */
package rgsr_pkg;

  localparam int MAX_DIM      = 1024;
  localparam int REGION_COUNT = 4;

  localparam int CW = 10;  // cell index width
  localparam int SW = 11;  // size width
  localparam int AW = 14;  // signed working width

  localparam int ID_W = $clog2(REGION_COUNT);

  typedef logic [CW-1:0]        coord_t;
  typedef logic [SW-1:0]        size_t;
  typedef logic signed [AW-1:0] sval_t;
  typedef logic [ID_W-1:0]      rid_t;

  // configuration register indexes
  localparam logic [1:0] REG_GRID_ROWS = 2'd0;
  localparam logic [1:0] REG_GRID_COLS = 2'd1;
  localparam logic [1:0] REG_START_ROW = 2'd2;
  localparam logic [1:0] REG_START_COL = 2'd3;

  localparam rid_t RID_TOP_LEFT     = rid_t'(0);
  localparam rid_t RID_TOP_RIGHT    = rid_t'(1);
  localparam rid_t RID_BOTTOM_LEFT  = rid_t'(2);
  localparam rid_t RID_BOTTOM_RIGHT = rid_t'(3);

  localparam size_t GRID_RESET = size_t'(MAX_DIM & 2047);
  localparam sval_t SIZE_MAX   = sval_t'(2047);

  typedef struct packed {
    coord_t row;
    coord_t col;
    size_t  rows;
    size_t  cols;
  } region_t;

  typedef struct packed {
    logic                         ok;
    region_t [REGION_COUNT-1:0]   regions;
  } split_t;

  function automatic sval_t ext_c(input coord_t v);
    return sval_t'({{(AW-CW){1'b0}}, v});
  endfunction

  function automatic sval_t ext_s(input size_t v);
    return sval_t'({{(AW-SW){1'b0}}, v});
  endfunction

  function automatic sval_t wrap_once(input sval_t v, input sval_t n);
    sval_t r;
    if (v < 0) begin
      r = v + n;
    end else if (v >= n) begin
      r = v - n;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic size_t clamp_size(input sval_t v);
    size_t r;
    if (v < 0) begin
      r = '0;
    end else if (v > SIZE_MAX) begin
      r = size_t'(SIZE_MAX);
    end else begin
      r = v[SW-1:0];
    end
    return r;
  endfunction

endpackage

/* hw/rtl/rgsr_emit.sv */
module rgsr_emit
  import rgsr_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  split_t  in_split,
  output logic    in_take,
  input  logic    out_ready,
  output logic    out_valid,
  output logic    out_ok,
  output rid_t    out_id,
  output region_t out_piece,
  output logic    out_last
);

  logic   held_valid;
  split_t held;
  rid_t   idx;
  logic   pop;
  logic   final_one;

  assign pop       = held_valid && (!out_valid || out_ready);
  assign final_one = !held.ok || (idx == rid_t'(REGION_COUNT - 1));
  assign in_take   = !held_valid || (pop && final_one);

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      out_valid  <= 1'b0;
      idx        <= '0;
    end else begin
      if (in_take) begin
        held_valid <= in_valid;
      end
      if (pop) begin
        out_valid <= 1'b1;
        idx       <= final_one ? '0 : idx + rid_t'(1);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && in_valid) begin
      held <= in_split;
    end
    if (pop) begin
      out_ok   <= held.ok;
      out_last <= final_one;
      if (held.ok) begin
        out_id    <= idx;
        out_piece <= held.regions[idx];
      end else begin
        // rejected request: one all-zero result
        out_id    <= '0;
        out_piece <= '0;
      end
    end
  end

endmodule

/* hw/rtl/ring_grid_submap_region_split.sv */
// Ring grid submap region split.
// A request arrives on the s_axis channel: corner cell and span of a submap
// inside a circular grid buffer. The block splits it into the four quadrant
// rectangles relative to the configured start offset and sends them on the
// m_axis channel in region order top-left, top-right, bottom-left,
// bottom-right; tlast marks the fourth. Unused regions come out as zeros.
// A request that cannot be split gives a single result with ok low and
// tlast high.
// Grid size and start offset are written through cfg_we/cfg_addr/cfg_data;
// the user must write them only while no request is in flight, which the
// block itself does not enforce. An input transfer passes through stage 1,
// stage 2 and the emitter's held split before reaching the output register.
// Each accepted request sends four results through the single output
// register, a rejected request one. The two compute stages accept a new
// request while the previous one is still being sent.
// Reset clears all valid bits and loads the grid size with 1024 and the
// start offset with zero. When the receiver stalls, the output register
// holds its result and the stages fill up behind it; tready drops once
// they are full, and nothing is lost or repeated.
module ring_grid_submap_region_split
  import rgsr_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [10:0] cfg_data,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // corner_row[9:0], corner_col[19:10], span_rows[30:20], span_cols[41:31], zero pad
  input  logic [47:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // piece_row[9:0], piece_col[19:10], piece_rows[30:20], piece_cols[41:31], zero pad
  output logic [47:0] m_axis_tdata,
  // ok[0], region_id[2:1]
  output logic [2:0]  m_axis_tuser,
  output logic        m_axis_tlast
);

  typedef struct packed {
    coord_t cr;
    coord_t cc;
    size_t  sr;
    size_t  sc;
    sval_t  dr;
    sval_t  dc;
    sval_t  er;
    sval_t  ec;
    sval_t  hr;
    sval_t  hc;
  } st1_t;

  typedef struct packed {
    coord_t cr;
    coord_t cc;
    size_t  sr;
    size_t  sc;
    sval_t  ur;
    sval_t  uc;
    sval_t  br;
    sval_t  bc;
    sval_t  hr;
    sval_t  hc;
    sval_t  lr;
    sval_t  lc;
  } st2_t;

  size_t  grid_rows;
  size_t  grid_cols;
  coord_t start_row;
  coord_t start_col;

  logic   v1;
  logic   v2;
  st1_t   s1;
  st2_t   s2;
  logic   adv1;
  logic   adv2;
  logic   take;

  coord_t in_cr;
  coord_t in_cc;
  size_t  in_sr;
  size_t  in_sc;

  sval_t  gr;
  sval_t  gc;
  sval_t  str;
  sval_t  stc;

  split_t  split;
  logic    ovf;
  logic    [1:0] qa;
  logic    [1:0] qb;

  logic    o_ok;
  rid_t    o_id;
  region_t o_piece;
  logic    o_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows <= GRID_RESET;
      grid_cols <= GRID_RESET;
      start_row <= '0;
      start_col <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_GRID_ROWS: grid_rows <= cfg_data[SW-1:0];
        REG_GRID_COLS: grid_cols <= cfg_data[SW-1:0];
        REG_START_ROW: start_row <= cfg_data[CW-1:0];
        REG_START_COL: start_col <= cfg_data[CW-1:0];
        default: ;
      endcase
    end
  end

  assign in_cr = s_axis_tdata[9:0];
  assign in_cc = s_axis_tdata[19:10];
  assign in_sr = s_axis_tdata[30:20];
  assign in_sc = s_axis_tdata[41:31];

  assign gr  = ext_s(grid_rows);
  assign gc  = ext_s(grid_cols);
  assign str = ext_c(start_row);
  assign stc = ext_c(start_col);

  assign adv2          = !v2 || take;
  assign adv1          = !v1 || adv2;
  assign s_axis_tready = adv1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      if (adv1) begin
        v1 <= s_axis_tvalid;
      end
      if (adv2) begin
        v2 <= v1;
      end
    end
  end

  // stage 1: offsets, far corner and distance to the buffer edge
  always_ff @(posedge clk) begin
    if (adv1 && s_axis_tvalid) begin
      s1.cr <= in_cr;
      s1.cc <= in_cc;
      s1.sr <= in_sr;
      s1.sc <= in_sc;
      s1.dr <= ext_c(in_cr) - str;
      s1.dc <= ext_c(in_cc) - stc;
      s1.er <= ext_c(in_cr) + ext_s(in_sr) - sval_t'(1);
      s1.ec <= ext_c(in_cc) + ext_s(in_sc) - sval_t'(1);
      s1.hr <= gr - ext_c(in_cr);
      s1.hc <= gc - ext_c(in_cc);
    end
  end

  // stage 2: wrap into the ring, remainder past the edge
  always_ff @(posedge clk) begin
    if (adv2 && v1) begin
      s2.cr <= s1.cr;
      s2.cc <= s1.cc;
      s2.sr <= s1.sr;
      s2.sc <= s1.sc;
      if (start_row == '0 && start_col == '0) begin
        s2.ur <= ext_c(s1.cr);
        s2.uc <= ext_c(s1.cc);
      end else begin
        s2.ur <= wrap_once(s1.dr, gr);
        s2.uc <= wrap_once(s1.dc, gc);
      end
      s2.br <= wrap_once(s1.er, gr);
      s2.bc <= wrap_once(s1.ec, gc);
      s2.hr <= s1.hr;
      s2.hc <= s1.hc;
      s2.lr <= ext_s(s1.sr) - s1.hr;
      s2.lc <= ext_s(s1.sc) - s1.hc;
    end
  end

  // stage 3: overflow check, quadrant pair and rectangle selection
  always_comb begin
    ovf = ((s2.ur + ext_s(s2.sr)) > gr) && ((s2.uc + ext_s(s2.sc)) > gc);
    qa  = {ext_c(s2.cr) < str, ext_c(s2.cc) < stc};
    qb  = {s2.br < str, s2.bc < stc};
    split    = '0;
    split.ok = !ovf;
    if (!ovf) begin
      case ({qa, qb})
        4'b00_00: begin
          split.regions[RID_TOP_LEFT] = '{s2.cr, s2.cc, s2.sr, s2.sc};
        end
        4'b00_01: begin
          split.regions[RID_TOP_LEFT]  = '{s2.cr, s2.cc, s2.sr, clamp_size(s2.hc)};
          split.regions[RID_TOP_RIGHT] = '{s2.cr, '0, s2.sr, clamp_size(s2.lc)};
        end
        4'b00_10: begin
          split.regions[RID_TOP_LEFT]    = '{s2.cr, s2.cc, clamp_size(s2.hr), s2.sc};
          split.regions[RID_BOTTOM_LEFT] = '{'0, s2.cc, clamp_size(s2.lr), s2.sc};
        end
        4'b00_11: begin
          split.regions[RID_TOP_LEFT] =
            '{s2.cr, s2.cc, clamp_size(s2.hr), clamp_size(s2.hc)};
          split.regions[RID_TOP_RIGHT] =
            '{s2.cr, '0, clamp_size(s2.hr), clamp_size(s2.lc)};
          split.regions[RID_BOTTOM_LEFT] =
            '{'0, s2.cc, clamp_size(s2.lr), clamp_size(s2.hc)};
          split.regions[RID_BOTTOM_RIGHT] =
            '{'0, '0, clamp_size(s2.lr), clamp_size(s2.lc)};
        end
        4'b01_01: begin
          split.regions[RID_TOP_RIGHT] = '{s2.cr, s2.cc, s2.sr, s2.sc};
        end
        4'b01_11: begin
          split.regions[RID_TOP_RIGHT]    = '{s2.cr, s2.cc, clamp_size(s2.hr), s2.sc};
          split.regions[RID_BOTTOM_RIGHT] = '{'0, s2.cc, clamp_size(s2.lr), s2.sc};
        end
        4'b10_10: begin
          split.regions[RID_BOTTOM_LEFT] = '{s2.cr, s2.cc, s2.sr, s2.sc};
        end
        4'b10_11: begin
          split.regions[RID_BOTTOM_LEFT]  = '{s2.cr, s2.cc, s2.sr, clamp_size(s2.hc)};
          split.regions[RID_BOTTOM_RIGHT] = '{s2.cr, '0, s2.sr, clamp_size(s2.lc)};
        end
        4'b11_11: begin
          split.regions[RID_BOTTOM_RIGHT] = '{s2.cr, s2.cc, s2.sr, s2.sc};
        end
        default: begin
          // far corner in a quadrant that cannot follow the near one
          split.ok = 1'b0;
        end
      endcase
    end
  end

  rgsr_emit u_emit (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (v2),
    .in_split  (split),
    .in_take   (take),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ok    (o_ok),
    .out_id    (o_id),
    .out_piece (o_piece),
    .out_last  (o_last)
  );

  assign m_axis_tdata = {6'd0, o_piece.cols, o_piece.rows, o_piece.col, o_piece.row};
  assign m_axis_tuser = {o_id, o_ok};
  assign m_axis_tlast = o_last;

endmodule

/* hw/rtl/rgsr_checker.sv */
module rgsr_checker
  import rgsr_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [47:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // nothing is sent in the cycle after reset
  a_idle_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // empty stages take a transfer right after reset
  a_ready_after_reset: assert property (@(posedge clk)
    (!rst && $past(rst)) |-> s_axis_tready)
    else $error("input not ready right after reset");

  // a rejection is a single all-zero result
  a_reject_form: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tuser[0]) |->
      (m_axis_tlast && m_axis_tdata == '0 && m_axis_tuser[2:1] == '0))
    else $error("malformed rejection result");

  // the fourth region and only it closes an accepted request
  a_last_region: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |->
      (m_axis_tlast == (m_axis_tuser[2:1] == RID_BOTTOM_RIGHT)))
    else $error("tlast does not match region id");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
       && $stable(m_axis_tlast)))
    else $error("stalled result changed");

endmodule

bind ring_grid_submap_region_split rgsr_checker u_rgsr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
